// File: src/tpp_pkg.sv
// Shared types, codes and character constants for the text packet header parser.
package tpp_pkg;

    // One input word: a restart command or one stream byte.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } item_t;

    // One result word per input word.
    typedef struct packed {
        logic [2:0]  tag;
        logic [7:0]  data_out;
        logic        line_end;
        logic        packet_end;
        logic        error_now;
        logic [3:0]  error_code;
        logic [23:0] body_length;
    } result_t;

    typedef enum logic [3:0] {
        PH_PROTO_START,
        PH_PROTO,
        PH_METHOD_START,
        PH_METHOD,
        PH_HDR_START,
        PH_NAME,
        PH_SKIP,
        PH_VALUE,
        PH_BODY
    } phase_t;

    // Parser control state that does not depend on the length width.
    typedef struct packed {
        phase_t     phase;
        logic       cr_seen;
        logic [3:0] match_pos;
        logic       match_ok;
        logic       len_active;
        logic       digits_done;
        logic       len_seen;
        logic [3:0] sticky_err;
    } ctrl_state_t;

    localparam logic [2:0] TAG_FRAMING  = 3'd0;
    localparam logic [2:0] TAG_PROTOCOL = 3'd1;
    localparam logic [2:0] TAG_METHOD   = 3'd2;
    localparam logic [2:0] TAG_NAME     = 3'd3;
    localparam logic [2:0] TAG_VALUE    = 3'd4;
    localparam logic [2:0] TAG_DIGIT    = 3'd5;
    localparam logic [2:0] TAG_BODY     = 3'd6;
    localparam logic [2:0] TAG_DISCARD  = 3'd7;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_EMPTY_FIRST  = 4'd1;
    localparam logic [3:0] ERR_PROTOCOL     = 4'd2;
    localparam logic [3:0] ERR_METHOD       = 4'd3;
    localparam logic [3:0] ERR_NAME         = 4'd4;
    localparam logic [3:0] ERR_NO_VALUE     = 4'd5;
    localparam logic [3:0] ERR_VALUE_CHAR   = 4'd6;
    localparam logic [3:0] ERR_DUP_LENGTH   = 4'd7;
    localparam logic [3:0] ERR_BAD_SIZE     = 4'd8;
    localparam logic [3:0] ERR_BAD_LINE_END = 4'd9;

    localparam logic [7:0] CH_LF         = 8'd10;
    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_DASH       = 8'd45;
    localparam logic [7:0] CH_COLON      = 8'd58;
    localparam logic [7:0] CH_UNDERSCORE = 8'd95;
    localparam logic [7:0] CH_PRINT_LO   = 8'd32;
    localparam logic [7:0] CH_PRINT_HI   = 8'd126;
    localparam logic [7:0] CH_CASE_DIFF  = 8'd32;

    localparam logic [3:0] LEN_NAME_CHARS = 4'd14;

    // Lowercase spelling of the length header name, one character per position.
    function automatic logic [7:0] len_name_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

// File: src/tpp_len_acc.sv
// Saturating decimal length accumulator and content length size check.
module tpp_len_acc #(
    parameter int LENGTH_BITS = 24
) (
    input  logic [LENGTH_BITS:0]   acc,
    input  logic [3:0]             digit,
    input  logic [LENGTH_BITS-1:0] max_len,
    output logic [LENGTH_BITS:0]   acc_step,
    output logic                   size_bad
);

    localparam int WIDE = LENGTH_BITS + 5;
    localparam logic [WIDE-1:0] SAT = WIDE'(1) << LENGTH_BITS;

    logic [WIDE-1:0] acc_wide;
    logic [WIDE-1:0] times_ten;

    // Times ten as two shifted copies, so no multiplier is needed.
    assign acc_wide  = WIDE'(acc);
    assign times_ten = (acc_wide << 3) + (acc_wide << 1) + WIDE'(digit);
    assign acc_step  = (times_ten > SAT) ? SAT[LENGTH_BITS:0] : times_ten[LENGTH_BITS:0];

    assign size_bad = (acc == '0) || (acc > {1'b0, max_len});

endmodule

// File: src/tpp_step.sv
// Per-byte parser logic: next state and the result word for one input word.
module tpp_step #(
    parameter int LENGTH_BITS = 24
) (
    input  tpp_pkg::item_t         item,
    input  tpp_pkg::ctrl_state_t   st,
    input  logic [LENGTH_BITS:0]   acc,
    input  logic [LENGTH_BITS-1:0] remain,
    input  logic [LENGTH_BITS-1:0] max_len,
    output tpp_pkg::ctrl_state_t   st_next,
    output logic [LENGTH_BITS:0]   acc_next,
    output logic [LENGTH_BITS-1:0] remain_next,
    output tpp_pkg::result_t       res
);

    logic [7:0]             c;
    logic [7:0]             lc;
    logic                   is_up;
    logic                   is_lo;
    logic                   is_dig;
    logic                   is_tail;
    logic                   is_print;
    logic [LENGTH_BITS:0]   acc_step;
    logic                   size_bad;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic [LENGTH_BITS-1:0] len_low;
    logic [2:0]             tag;
    logic [3:0]             err;
    logic                   le;
    logic                   pe;
    logic                   finish;

    assign c        = item.data_byte;
    assign is_up    = (c >= "A") && (c <= "Z");
    assign is_lo    = (c >= "a") && (c <= "z");
    assign is_dig   = (c >= "0") && (c <= "9");
    assign is_tail  = is_up || is_dig || (c == tpp_pkg::CH_UNDERSCORE);
    assign is_print = (c >= tpp_pkg::CH_PRINT_LO) && (c < tpp_pkg::CH_PRINT_HI);
    assign lc       = is_up ? c + tpp_pkg::CH_CASE_DIFF : c;
    assign remain_dec = (remain != '0) ? remain - LENGTH_BITS'(1) : remain;

    tpp_len_acc #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_len_acc (
        .acc      (acc),
        .digit    (c[3:0]),
        .max_len  (max_len),
        .acc_step (acc_step),
        .size_bad (size_bad)
    );

    always_comb
    begin
        st_next     = st;
        acc_next    = acc;
        remain_next = remain;
        tag         = tpp_pkg::TAG_FRAMING;
        err         = tpp_pkg::ERR_NONE;
        le          = 1'b0;
        pe          = 1'b0;
        finish      = 1'b0;
        res         = '0;
        len_low     = '0;

        if (item.cmd)
        begin
            st_next.phase       = tpp_pkg::PH_PROTO_START;
            st_next.cr_seen     = 1'b0;
            st_next.match_pos   = '0;
            st_next.match_ok    = 1'b1;
            st_next.len_active  = 1'b0;
            st_next.digits_done = 1'b0;
            st_next.len_seen    = 1'b0;
            st_next.sticky_err  = tpp_pkg::ERR_NONE;
            acc_next            = '0;
            remain_next         = '0;
            res.tag             = tpp_pkg::TAG_DISCARD;
        end
        else
        begin
            if (st.sticky_err != tpp_pkg::ERR_NONE)
            begin
                tag = tpp_pkg::TAG_DISCARD;
            end
            else if (st.cr_seen)
            begin
                st_next.cr_seen = 1'b0;
                if (c != tpp_pkg::CH_LF)
                begin
                    err = tpp_pkg::ERR_BAD_LINE_END;
                end
                else
                begin
                    case (st.phase)
                        tpp_pkg::PH_PROTO_START:
                        begin
                            err = tpp_pkg::ERR_EMPTY_FIRST;
                        end
                        tpp_pkg::PH_METHOD:
                        begin
                            le            = 1'b1;
                            st_next.phase = tpp_pkg::PH_HDR_START;
                        end
                        tpp_pkg::PH_HDR_START:
                        begin
                            if (st.len_seen)
                            begin
                                remain_next   = acc[LENGTH_BITS-1:0];
                                st_next.phase = tpp_pkg::PH_BODY;
                            end
                            else
                            begin
                                pe     = 1'b1;
                                finish = 1'b1;
                            end
                        end
                        tpp_pkg::PH_VALUE:
                        begin
                            if (st.len_active)
                            begin
                                if (st.len_seen)
                                begin
                                    err = tpp_pkg::ERR_DUP_LENGTH;
                                end
                                else if (size_bad)
                                begin
                                    err = tpp_pkg::ERR_BAD_SIZE;
                                end
                                else
                                begin
                                    st_next.len_seen = 1'b1;
                                end
                            end
                            if (err == tpp_pkg::ERR_NONE)
                            begin
                                le                  = 1'b1;
                                st_next.phase       = tpp_pkg::PH_HDR_START;
                                st_next.match_pos   = '0;
                                st_next.match_ok    = 1'b1;
                                st_next.len_active  = 1'b0;
                                st_next.digits_done = 1'b0;
                            end
                        end
                        default:
                        begin
                            err = tpp_pkg::ERR_BAD_LINE_END;
                        end
                    endcase
                end
            end
            else
            begin
                case (st.phase)
                    tpp_pkg::PH_PROTO_START:
                    begin
                        if (c == tpp_pkg::CH_CR)
                        begin
                            st_next.cr_seen = 1'b1;
                        end
                        else if (is_up)
                        begin
                            tag           = tpp_pkg::TAG_PROTOCOL;
                            st_next.phase = tpp_pkg::PH_PROTO;
                        end
                        else
                        begin
                            err = tpp_pkg::ERR_PROTOCOL;
                        end
                    end
                    tpp_pkg::PH_PROTO:
                    begin
                        if (c == tpp_pkg::CH_SPACE)
                        begin
                            st_next.phase = tpp_pkg::PH_METHOD_START;
                        end
                        else if (is_tail)
                        begin
                            tag = tpp_pkg::TAG_PROTOCOL;
                        end
                        else
                        begin
                            err = tpp_pkg::ERR_PROTOCOL;
                        end
                    end
                    tpp_pkg::PH_METHOD_START:
                    begin
                        if (is_up)
                        begin
                            tag           = tpp_pkg::TAG_METHOD;
                            st_next.phase = tpp_pkg::PH_METHOD;
                        end
                        else
                        begin
                            err = tpp_pkg::ERR_METHOD;
                        end
                    end
                    tpp_pkg::PH_METHOD:
                    begin
                        if (c == tpp_pkg::CH_CR)
                        begin
                            st_next.cr_seen = 1'b1;
                        end
                        else if (is_tail)
                        begin
                            tag = tpp_pkg::TAG_METHOD;
                        end
                        else
                        begin
                            err = tpp_pkg::ERR_METHOD;
                        end
                    end
                    tpp_pkg::PH_HDR_START, tpp_pkg::PH_NAME:
                    begin
                        if ((st.phase == tpp_pkg::PH_HDR_START) && (c == tpp_pkg::CH_CR))
                        begin
                            st_next.cr_seen = 1'b1;
                        end
                        else if ((st.phase == tpp_pkg::PH_NAME) && (c == tpp_pkg::CH_COLON))
                        begin
                            st_next.len_active  = st.match_ok &&
                                                  (st.match_pos == tpp_pkg::LEN_NAME_CHARS);
                            st_next.digits_done = 1'b0;
                            st_next.phase       = tpp_pkg::PH_SKIP;
                        end
                        else if (is_up || is_lo ||
                                 ((st.phase == tpp_pkg::PH_NAME) &&
                                  (is_dig || (c == tpp_pkg::CH_UNDERSCORE) ||
                                   (c == tpp_pkg::CH_DASH))))
                        begin
                            tag           = tpp_pkg::TAG_NAME;
                            st_next.phase = tpp_pkg::PH_NAME;
                            if (st.match_ok && (st.match_pos < tpp_pkg::LEN_NAME_CHARS) &&
                                (lc == tpp_pkg::len_name_char(st.match_pos)))
                            begin
                                st_next.match_pos = st.match_pos + 4'd1;
                            end
                            else
                            begin
                                st_next.match_ok = 1'b0;
                            end
                        end
                        else
                        begin
                            err = tpp_pkg::ERR_NAME;
                        end
                    end
                    tpp_pkg::PH_SKIP, tpp_pkg::PH_VALUE:
                    begin
                        if ((st.phase == tpp_pkg::PH_SKIP) && (c == tpp_pkg::CH_SPACE))
                        begin
                            tag = tpp_pkg::TAG_FRAMING;
                        end
                        else if (c == tpp_pkg::CH_CR)
                        begin
                            if (st.phase == tpp_pkg::PH_SKIP)
                            begin
                                err = tpp_pkg::ERR_NO_VALUE;
                            end
                            else
                            begin
                                st_next.cr_seen = 1'b1;
                            end
                        end
                        else if (!is_print)
                        begin
                            err = tpp_pkg::ERR_VALUE_CHAR;
                        end
                        else
                        begin
                            st_next.phase = tpp_pkg::PH_VALUE;
                            tag           = tpp_pkg::TAG_VALUE;
                            if (st.len_active && !st.digits_done)
                            begin
                                if (is_dig)
                                begin
                                    tag = tpp_pkg::TAG_DIGIT;
                                    if (!st.len_seen)
                                    begin
                                        acc_next = acc_step;
                                    end
                                end
                                else
                                begin
                                    st_next.digits_done = 1'b1;
                                end
                            end
                        end
                    end
                    tpp_pkg::PH_BODY:
                    begin
                        tag         = tpp_pkg::TAG_BODY;
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            pe     = 1'b1;
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        err = tpp_pkg::ERR_BAD_LINE_END;
                    end
                endcase
            end

            if (err != tpp_pkg::ERR_NONE)
            begin
                st_next.sticky_err = err;
                tag                = tpp_pkg::TAG_DISCARD;
                le                 = 1'b0;
                pe                 = 1'b0;
                finish             = 1'b0;
            end

            len_low         = st_next.len_seen ? acc_next[LENGTH_BITS-1:0] : '0;
            res.tag         = tag;
            res.data_out    = c;
            res.line_end    = le;
            res.packet_end  = pe;
            res.error_now   = (err != tpp_pkg::ERR_NONE);
            res.error_code  = st_next.sticky_err;
            res.body_length = 24'(len_low);

            // A finished packet starts the next one from a clean state.
            if (finish)
            begin
                st_next.phase       = tpp_pkg::PH_PROTO_START;
                st_next.cr_seen     = 1'b0;
                st_next.match_pos   = '0;
                st_next.match_ok    = 1'b1;
                st_next.len_active  = 1'b0;
                st_next.digits_done = 1'b0;
                st_next.len_seen    = 1'b0;
                acc_next            = '0;
                remain_next         = '0;
            end
        end
    end

endmodule

// File: src/text_packet_header_parser.sv
// Flow: an accepted word waits in the input register and passes the parser logic into
// the result register when it is free; a held result delays it until result_stall drops.
// Throughput: one word per cycle, set by the single pass of parser logic between the
// input register and the result register; a stalled result blocks intake only once the
// input register also holds a word.
// Reset: rst_n clears the parser state, the sticky error and both valid flags at once,
// and sets max_body_length to 65535 masked to LENGTH_BITS bits.
module text_packet_header_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tpp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output tpp_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [23:0]      cfg_data
);

    // Input register: holds one accepted word until the parser pass can run.
    logic                   in_valid_reg;
    logic                   in_valid_next;
    tpp_pkg::item_t         in_reg;

    // Result register: holds the finished result word until it is taken.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    tpp_pkg::result_t       out_reg;

    // Parser state. It advances only when a word moves from input to result.
    tpp_pkg::ctrl_state_t   st_reg;
    tpp_pkg::ctrl_state_t   st_next;
    logic [LENGTH_BITS:0]   acc_reg;
    logic [LENGTH_BITS:0]   acc_next;
    logic [LENGTH_BITS-1:0] remain_reg;
    logic [LENGTH_BITS-1:0] remain_next;
    logic [LENGTH_BITS-1:0] max_len_reg;
    tpp_pkg::result_t       step_res;

    logic                   out_free;
    logic                   advance;
    logic                   accept;

    // The result register is free when it is empty or being emptied this cycle.
    assign out_free = !out_valid_reg || !result_stall;
    assign advance  = in_valid_reg && out_free;
    // The input register refills in the same cycle that it drains, so a new word
    // is taken every cycle while the output side keeps up.
    assign item_stall = in_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);

    // The configuration register is always writable; the user must keep the block idle
    // whenever it is written, as the block itself does not enforce it.
    assign cfg_ready = 1'b1;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    tpp_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .item        (in_reg),
        .st          (st_reg),
        .acc         (acc_reg),
        .remain      (remain_reg),
        .max_len     (max_len_reg),
        .st_next     (st_next),
        .acc_next    (acc_next),
        .remain_next (remain_next),
        .res         (step_res)
    );

    // Control state, parser state and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            st_reg.phase         <= tpp_pkg::PH_PROTO_START;
            st_reg.cr_seen       <= 1'b0;
            st_reg.match_pos     <= '0;
            st_reg.match_ok      <= 1'b1;
            st_reg.len_active    <= 1'b0;
            st_reg.digits_done   <= 1'b0;
            st_reg.len_seen      <= 1'b0;
            st_reg.sticky_err    <= tpp_pkg::ERR_NONE;
            acc_reg              <= '0;
            remain_reg           <= '0;
            max_len_reg          <= LENGTH_BITS'(65535);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                st_reg     <= st_next;
                acc_reg    <= acc_next;
                remain_reg <= remain_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                max_len_reg <= LENGTH_BITS'(cfg_data);
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

endmodule

// File: tb/tb_text_packet_header_parser.sv
// Self-checking testbench for the text packet header parser with random packet streams.
`timescale 1ns / 1ps

module tb_text_packet_header_parser;

    localparam int LEN_BITS = 24;
    localparam logic [24:0] LEN_SAT = 25'd1 << LEN_BITS;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [23:0] RESET_MAX_LEN = 24'd65535;

    localparam logic [7:0] CH_A_UP = "A";
    localparam logic [7:0] CH_Z_UP = "Z";
    localparam logic [7:0] CH_A_LO = "a";
    localparam logic [7:0] CH_Z_LO = "z";
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_S_LO = "s";
    localparam logic [8*14-1:0] LENGTH_HEADER = "content-length";

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    tpp_pkg::item_t     item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    tpp_pkg::result_t   result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [23:0]        cfg_data = '0;

    // Expected result words, oldest first.
    tpp_pkg::result_t   expected_tagged[$];
    tpp_pkg::result_t   want;
    int                 fail_count = 0;
    int                 bytes_sent = 0;
    int                 quiet_cycles = 0;
    int                 stall_left = 0;
    bit                 idle_on = 1'b1;

    // Bytes of the packet under construction.
    logic [7:0]         pkt[$];

    // Parser state mirrored by the predictor.
    tpp_pkg::phase_t    m_phase;
    logic               m_cr;
    logic [3:0]         m_match_pos;
    logic               m_match_ok;
    logic               m_len_active;
    logic               m_digits_done;
    logic               m_len_seen;
    logic [24:0]        m_len_acc;
    logic [23:0]        m_body_left;
    logic [3:0]         m_err;
    logic [23:0]        m_max_len;

    text_packet_header_parser #(
        .LENGTH_BITS(LEN_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit is_upper(input logic [7:0] c);
        return c >= CH_A_UP && c <= CH_Z_UP;
    endfunction

    function automatic bit is_lower(input logic [7:0] c);
        return c >= CH_A_LO && c <= CH_Z_LO;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_token_tail(input logic [7:0] c);
        return is_upper(c) || is_digit(c) || c == tpp_pkg::CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] header_char(input int pos);
        return LENGTH_HEADER[8*(13-pos) +: 8];
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic start_packet();
        m_phase       = tpp_pkg::PH_PROTO_START;
        m_cr          = 1'b0;
        m_match_pos   = '0;
        m_match_ok    = 1'b1;
        m_len_active  = 1'b0;
        m_digits_done = 1'b0;
        m_len_seen    = 1'b0;
        m_len_acc     = '0;
        m_body_left   = '0;
    endtask

    task automatic reset_model();
        start_packet();
        m_err     = tpp_pkg::ERR_NONE;
        m_max_len = RESET_MAX_LEN;
    endtask

    // A character of a header value; digits of the length header feed the accumulator
    // until the first non-digit.
    task automatic value_char(input logic [7:0] c, output logic [2:0] tg, output bit bad);
        logic [31:0] v;
        bad = 1'b0;
        tg  = tpp_pkg::TAG_VALUE;
        if (!(c >= tpp_pkg::CH_PRINT_LO && c < tpp_pkg::CH_PRINT_HI))
        begin
            bad = 1'b1;
        end
        else
        begin
            m_phase = tpp_pkg::PH_VALUE;
            if (m_len_active && !m_digits_done)
            begin
                if (is_digit(c))
                begin
                    if (!m_len_seen)
                    begin
                        v = m_len_acc * 10 + (c - CH_ZERO);
                        m_len_acc = (v > LEN_SAT) ? LEN_SAT : v[24:0];
                    end
                    tg = tpp_pkg::TAG_DIGIT;
                end
                else
                begin
                    m_digits_done = 1'b1;
                end
            end
        end
    endtask

    // Works out the result word for one accepted input word and advances the state.
    task automatic tag_byte(input tpp_pkg::item_t w, output tpp_pkg::result_t r);
        logic [7:0] c;
        logic [7:0] lc;
        logic [2:0] tg;
        logic [3:0] er;
        logic       le;
        logic       pe;
        logic       fin;
        bit         bad;
        c   = w.data_byte;
        tg  = tpp_pkg::TAG_FRAMING;
        er  = tpp_pkg::ERR_NONE;
        le  = 1'b0;
        pe  = 1'b0;
        fin = 1'b0;
        r   = '0;
        if (w.cmd)
        begin
            start_packet();
            m_err = tpp_pkg::ERR_NONE;
            r.tag = tpp_pkg::TAG_DISCARD;
        end
        else
        begin
            if (m_err != tpp_pkg::ERR_NONE)
            begin
                tg = tpp_pkg::TAG_DISCARD;
            end
            else if (m_cr)
            begin
                m_cr = 1'b0;
                if (c != tpp_pkg::CH_LF)
                begin
                    er = tpp_pkg::ERR_BAD_LINE_END;
                end
                else
                begin
                    case (m_phase)
                        tpp_pkg::PH_PROTO_START: er = tpp_pkg::ERR_EMPTY_FIRST;
                        tpp_pkg::PH_METHOD:
                        begin
                            le = 1'b1;
                            m_phase = tpp_pkg::PH_HDR_START;
                        end
                        tpp_pkg::PH_HDR_START:
                        begin
                            if (m_len_seen)
                            begin
                                m_body_left = m_len_acc[23:0];
                                m_phase = tpp_pkg::PH_BODY;
                            end
                            else
                            begin
                                pe  = 1'b1;
                                fin = 1'b1;
                            end
                        end
                        tpp_pkg::PH_VALUE:
                        begin
                            // The length check runs on the LF that closes its header line.
                            if (m_len_active)
                            begin
                                if (m_len_seen) er = tpp_pkg::ERR_DUP_LENGTH;
                                else if (m_len_acc == 0 || m_len_acc > m_max_len)
                                    er = tpp_pkg::ERR_BAD_SIZE;
                                else m_len_seen = 1'b1;
                            end
                            if (er == tpp_pkg::ERR_NONE)
                            begin
                                le            = 1'b1;
                                m_phase       = tpp_pkg::PH_HDR_START;
                                m_match_pos   = '0;
                                m_match_ok    = 1'b1;
                                m_len_active  = 1'b0;
                                m_digits_done = 1'b0;
                            end
                        end
                        default: er = tpp_pkg::ERR_BAD_LINE_END;
                    endcase
                end
            end
            else
            begin
                case (m_phase)
                    tpp_pkg::PH_PROTO_START:
                    begin
                        if (c == tpp_pkg::CH_CR) m_cr = 1'b1;
                        else if (is_upper(c))
                        begin
                            tg = tpp_pkg::TAG_PROTOCOL;
                            m_phase = tpp_pkg::PH_PROTO;
                        end
                        else er = tpp_pkg::ERR_PROTOCOL;
                    end
                    tpp_pkg::PH_PROTO:
                    begin
                        if (c == tpp_pkg::CH_SPACE) m_phase = tpp_pkg::PH_METHOD_START;
                        else if (is_token_tail(c)) tg = tpp_pkg::TAG_PROTOCOL;
                        else er = tpp_pkg::ERR_PROTOCOL;
                    end
                    tpp_pkg::PH_METHOD_START:
                    begin
                        if (is_upper(c))
                        begin
                            tg = tpp_pkg::TAG_METHOD;
                            m_phase = tpp_pkg::PH_METHOD;
                        end
                        else er = tpp_pkg::ERR_METHOD;
                    end
                    tpp_pkg::PH_METHOD:
                    begin
                        if (c == tpp_pkg::CH_CR) m_cr = 1'b1;
                        else if (is_token_tail(c)) tg = tpp_pkg::TAG_METHOD;
                        else er = tpp_pkg::ERR_METHOD;
                    end
                    tpp_pkg::PH_HDR_START, tpp_pkg::PH_NAME:
                    begin
                        if (m_phase == tpp_pkg::PH_HDR_START && c == tpp_pkg::CH_CR)
                        begin
                            m_cr = 1'b1;
                        end
                        else if (m_phase == tpp_pkg::PH_NAME && c == tpp_pkg::CH_COLON)
                        begin
                            m_len_active  = m_match_ok &&
                                            m_match_pos == tpp_pkg::LEN_NAME_CHARS;
                            m_digits_done = 1'b0;
                            m_phase       = tpp_pkg::PH_SKIP;
                        end
                        else if (is_upper(c) || is_lower(c) ||
                                 (m_phase == tpp_pkg::PH_NAME &&
                                  (is_digit(c) || c == tpp_pkg::CH_UNDERSCORE ||
                                   c == tpp_pkg::CH_DASH)))
                        begin
                            lc = is_upper(c) ? c + tpp_pkg::CH_CASE_DIFF : c;
                            tg = tpp_pkg::TAG_NAME;
                            m_phase = tpp_pkg::PH_NAME;
                            // The name is matched case-insensitively against the length header.
                            if (m_match_ok && m_match_pos < tpp_pkg::LEN_NAME_CHARS &&
                                lc == header_char(m_match_pos))
                                m_match_pos = m_match_pos + 1'b1;
                            else
                                m_match_ok = 1'b0;
                        end
                        else
                        begin
                            er = tpp_pkg::ERR_NAME;
                        end
                    end
                    tpp_pkg::PH_SKIP:
                    begin
                        if (c == tpp_pkg::CH_SPACE) tg = tpp_pkg::TAG_FRAMING;
                        else if (c == tpp_pkg::CH_CR) er = tpp_pkg::ERR_NO_VALUE;
                        else
                        begin
                            value_char(c, tg, bad);
                            if (bad) er = tpp_pkg::ERR_VALUE_CHAR;
                        end
                    end
                    tpp_pkg::PH_VALUE:
                    begin
                        if (c == tpp_pkg::CH_CR) m_cr = 1'b1;
                        else
                        begin
                            value_char(c, tg, bad);
                            if (bad) er = tpp_pkg::ERR_VALUE_CHAR;
                        end
                    end
                    tpp_pkg::PH_BODY:
                    begin
                        tg = tpp_pkg::TAG_BODY;
                        if (m_body_left > 0) m_body_left = m_body_left - 1'b1;
                        if (m_body_left == 0)
                        begin
                            pe  = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    default: er = tpp_pkg::ERR_BAD_LINE_END;
                endcase
            end
            if (er != tpp_pkg::ERR_NONE)
            begin
                m_err = er;
                tg    = tpp_pkg::TAG_DISCARD;
                le    = 1'b0;
                pe    = 1'b0;
                fin   = 1'b0;
            end
            r.tag         = tg;
            r.data_out    = c;
            r.line_end    = le;
            r.packet_end  = pe;
            r.error_now   = (er != tpp_pkg::ERR_NONE);
            r.error_code  = m_err;
            r.body_length = m_len_seen ? m_len_acc[23:0] : 24'd0;
            if (fin) start_packet();
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one word, with an occasional idle burst in front, and records its prediction.
    task automatic send_word(input tpp_pkg::item_t w);
        tpp_pkg::result_t r;
        int               gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            repeat (gap)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
            end
        end
        @(negedge clk);
        item       <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        tag_byte(w, r);
        expected_tagged.push_back(r);
        bytes_sent++;
    endtask

    task automatic send_data(input logic [7:0] b);
        tpp_pkg::item_t w;
        w.cmd       = 1'b0;
        w.data_byte = b;
        send_word(w);
    endtask

    // The byte of a restart word is ignored, so it carries random content.
    task automatic send_restart();
        tpp_pkg::item_t w;
        w.cmd       = 1'b1;
        w.data_byte = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_data(s[i]);
    endtask

    // Lowers valid and waits until every predicted word has come back.
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_tagged.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_max_body_length(input logic [23:0] v);
        drain_results();
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        m_max_len = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------

    task automatic push_crlf();
        pkt.push_back(tpp_pkg::CH_CR);
        // Now and then the CR is followed by something other than LF.
        if ($urandom_range(0, 49) == 0) pkt.push_back(8'($urandom_range(0, 9)));
        else pkt.push_back(tpp_pkg::CH_LF);
    endtask

    // Protocol or method token: an uppercase letter, then letters, digits or underscores.
    task automatic push_token();
        int n;
        n = $urandom_range(0, 3);
        pkt.push_back(CH_A_UP + 8'($urandom_range(0, 25)));
        repeat (n)
        begin
            case ($urandom_range(0, 2))
                0: pkt.push_back(CH_A_UP + 8'($urandom_range(0, 25)));
                1: pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                default: pkt.push_back(tpp_pkg::CH_UNDERSCORE);
            endcase
        end
    endtask

    task automatic push_number(input int unsigned v);
        logic [7:0] digits[$];
        int         i;
        digits = {};
        do
        begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        for (i = 0; i < digits.size(); i++) pkt.push_back(digits[i]);
    endtask

    // Mostly small lengths; sometimes zero, one past the limit, or a runaway digit string
    // (returned as -1).
    function automatic int pick_length();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return int'(m_max_len) + 1;
            2: return -1;
            3: return (m_max_len <= 24'd8) ? int'(m_max_len) : $urandom_range(1, 8);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Appends a length header in random case; exact is cleared for a near-miss name.
    task automatic push_length_header(input int v, output bit exact);
        int         k;
        logic [7:0] ch;
        for (k = 0; k < 14; k++)
        begin
            ch = header_char(k);
            if (is_lower(ch) && $urandom_range(0, 1) == 1) ch = ch - tpp_pkg::CH_CASE_DIFF;
            pkt.push_back(ch);
        end
        exact = 1'b1;
        case ($urandom_range(0, 9))
            0:
            begin
                void'(pkt.pop_back());
                exact = 1'b0;
            end
            1:
            begin
                pkt.push_back(CH_S_LO);
                exact = 1'b0;
            end
            default: ;
        endcase
        pkt.push_back(tpp_pkg::CH_COLON);
        repeat ($urandom_range(0, 2)) pkt.push_back(tpp_pkg::CH_SPACE);
        if ($urandom_range(0, 3) == 0) pkt.push_back(CH_ZERO);
        if (v < 0)
        begin
            pkt.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(8, 11)) pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else
        begin
            push_number(v);
        end
        // Anything after the digits is ordinary value text.
        if ($urandom_range(0, 3) == 0)
        begin
            pkt.push_back(tpp_pkg::CH_SPACE);
            pkt.push_back(8'($urandom_range(33, 125)));
        end
        push_crlf();
    endtask

    task automatic push_other_header();
        int n;
        n = $urandom_range(0, 6);
        if ($urandom_range(0, 1) == 1) pkt.push_back(CH_A_UP + 8'($urandom_range(0, 25)));
        else pkt.push_back(CH_A_LO + 8'($urandom_range(0, 25)));
        repeat (n)
        begin
            case ($urandom_range(0, 4))
                0: pkt.push_back(CH_A_UP + 8'($urandom_range(0, 25)));
                1: pkt.push_back(CH_A_LO + 8'($urandom_range(0, 25)));
                2: pkt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                3: pkt.push_back(tpp_pkg::CH_UNDERSCORE);
                default: pkt.push_back(tpp_pkg::CH_DASH);
            endcase
        end
        pkt.push_back(tpp_pkg::CH_COLON);
        repeat ($urandom_range(0, 2)) pkt.push_back(tpp_pkg::CH_SPACE);
        case ($urandom_range(0, 19))
            // An empty value: the CR comes straight after the colon and spaces.
            0: ;
            // A character outside the printable range in the value.
            1:
            begin
                pkt.push_back(8'($urandom_range(33, 125)));
                if ($urandom_range(0, 1) == 1) pkt.push_back(8'($urandom_range(126, 255)));
                else pkt.push_back(8'($urandom_range(0, 9)));
            end
            default: repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(32, 125)));
        endcase
        push_crlf();
    endtask

    task automatic build_packet();
        int n_hdr;
        int len_slot;
        int len_val;
        int body_n;
        int i;
        int pos;
        bit exact;
        bit dup_exact;
        bit dup;
        pkt    = {};
        body_n = 0;
        if ($urandom_range(0, 24) == 0)
        begin
            // A packet that opens with its blank line.
            pkt.push_back(tpp_pkg::CH_CR);
            pkt.push_back(tpp_pkg::CH_LF);
        end
        else
        begin
            push_token();
            pkt.push_back(tpp_pkg::CH_SPACE);
            push_token();
            push_crlf();
            n_hdr    = $urandom_range(0, 3);
            len_slot = ($urandom_range(0, 9) < 6) ? $urandom_range(0, n_hdr) : -1;
            dup      = ($urandom_range(0, 9) == 0);
            for (i = 0; i <= n_hdr; i++)
            begin
                if (i == len_slot)
                begin
                    len_val = pick_length();
                    push_length_header(len_val, exact);
                    if (dup) push_length_header(pick_length(), dup_exact);
                    if (exact && len_val >= 1 && len_val <= 8) body_n = len_val;
                end
                if (i < n_hdr) push_other_header();
            end
            push_crlf();
            repeat (body_n) pkt.push_back(8'($urandom_range(0, 255)));
        end
        // A fifth of the packets get one byte overwritten, inserted or removed.
        if ($urandom_range(0, 4) == 0)
        begin
            pos = $urandom_range(0, pkt.size() - 1);
            case ($urandom_range(0, 3))
                0: pkt[pos] = 8'($urandom_range(0, 255));
                1: pkt.insert(pos, tpp_pkg::CH_CR);
                2: pkt.insert(pos, tpp_pkg::CH_LF);
                default: pkt.delete(pos);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A length-carrying packet with the byte extremes as body, then an empty first line
    // whose error holds over the next byte until a restart.
    task automatic test_directed_packet();
        send_restart();
        send_text("A B\r\n");
        send_text("cONTENT-lENGTH:  2\r\n");
        send_text("\r\n");
        send_data(8'h00);
        send_data(8'hFF);
        send_text("\r\n");
        send_data(8'hFF);
        send_restart();
    endtask

    task automatic run_random_packets(input int n_items);
        int             start_count;
        int             i;
        tpp_pkg::item_t w;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_items)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    w.cmd       = ($urandom_range(0, 7) == 0);
                    w.data_byte = 8'($urandom_range(0, 255));
                    send_word(w);
                end
            end
            build_packet();
            for (i = 0; i < pkt.size(); i++)
            begin
                if ($urandom_range(0, 199) == 0) send_restart();
                send_data(pkt[i]);
            end
            if (m_err != tpp_pkg::ERR_NONE || $urandom_range(0, 19) == 0) send_restart();
        end
    endtask

    task automatic test_default_limit();
        run_random_packets(400);
    endtask

    task automatic test_smallest_limit();
        write_max_body_length(24'd1);
        run_random_packets(250);
    endtask

    task automatic test_largest_limit();
        write_max_body_length(24'hFFFFFF);
        run_random_packets(250);
    endtask

    task automatic test_small_limit();
        write_max_body_length(24'($urandom_range(2, 6)));
        run_random_packets(250);
    endtask

    // Back-to-back words on both sides.
    task automatic test_full_rate();
        write_max_body_length(24'($urandom_range(1, 24'hFFFFFF)));
        idle_on = 1'b0;
        run_random_packets(350);
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls and watchdog
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_tagged.size() == 0)
            begin
                $error("result word %0h arrived with nothing expected", result);
                fail_count++;
            end
            else
            begin
                want = expected_tagged.pop_front();
                check_field("tag", want.tag, result.tag);
                check_field("data_out", want.data_out, result.data_out);
                check_field("line_end", want.line_end, result.line_end);
                check_field("packet_end", want.packet_end, result.packet_end);
                check_field("error_now", want.error_now, result.error_now);
                check_field("error_code", want.error_code, result.error_code);
                check_field("body_length", want.body_length, result.body_length);
            end
        end
    end

    // The receiver stalls in bursts of random length while idle_on is set.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left   <= $urandom_range(0, 12);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        reset_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_packet();
        test_default_limit();
        test_smallest_limit();
        test_largest_limit();
        test_small_limit();
        test_full_rate();
        drain_results();
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/tpp_pkg.sv
src/tpp_len_acc.sv
src/tpp_step.sv
src/text_packet_header_parser.sv
tb/tb_text_packet_header_parser.sv
